// ----- sv/lottery_scheduler_core_defines.svh -----
// Assertion macros used by the lottery scheduler checker.
`ifndef LOTTERY_SCHEDULER_CORE_DEFINES_SVH
`define LOTTERY_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSCH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsch: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LSCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsch: next-cycle check failed");

`endif

// ----- sv/lsch_pkg.sv -----
// Types and constants of the lottery scheduler.
package lsch_pkg;

    localparam int TICKET_W   = 16;
    localparam int RND_W      = 32;
    localparam int IDX_PORT_W = 4;
    localparam int OUT_TOT_W  = 20;
    localparam int RCNT_W     = $clog2(RND_W + 1);

    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 24;

    // request kinds
    localparam logic ACT_SET     = 1'b0;
    localparam logic ACT_RESCHED = 1'b1;

    // run states
    localparam logic [1:0] ST_OFF     = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_RUN,
        S_CHK_RUN,
        S_SUM,
        S_DIV,
        S_DIV_WAIT,
        S_SCAN,
        S_WIN,
        S_FIN
    } lsch_fsm_t;

    // table write command
    typedef struct packed {
        logic                en;
        logic [1:0]          state;
        logic [TICKET_W-1:0] tickets;
    } lsch_wr_t;

endpackage

// ----- sv/lsch_table.sv -----
// Process table: run state and tickets per entry, one write and one read port.
module lsch_table #(
    parameter int NUM_ENTRIES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsch_pkg::lsch_wr_t            wr,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [1:0]                    rd_state,
    output logic [lsch_pkg::TICKET_W-1:0] rd_tickets
);

    logic [1:0]                    state_mem [NUM_ENTRIES];
    logic [lsch_pkg::TICKET_W-1:0] tk_mem    [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]        valid_reg;

    logic [1:0]                    state_rd_reg;
    logic [lsch_pkg::TICKET_W-1:0] tk_rd_reg;
    logic                          vld_rd_reg;

    // entries never written read as not runnable with no tickets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            vld_rd_reg <= valid_reg[rd_addr];
            if (wr.en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            state_mem[wr_addr] <= wr.state;
            tk_mem[wr_addr]    <= wr.tickets;
        end
        state_rd_reg <= state_mem[rd_addr];
        tk_rd_reg    <= tk_mem[rd_addr];
    end

    assign rd_state   = vld_rd_reg ? state_rd_reg : lsch_pkg::ST_OFF;
    assign rd_tickets = vld_rd_reg ? tk_rd_reg : '0;

endmodule

// ----- sv/lsch_mod.sv -----
// Bit-serial remainder unit: one restoring step per cycle over the 32-bit draw.
module lsch_mod #(
    parameter int TOT_W = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lsch_pkg::RND_W-1:0] dividend,
    input  logic [TOT_W-1:0]           divisor,
    output logic                       done,
    output logic [TOT_W-1:0]           rem
);

    logic [lsch_pkg::RCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [lsch_pkg::RND_W-1:0]  dvd_reg, dvd_next;
    logic [TOT_W-1:0]            rem_reg, rem_next;
    logic [TOT_W:0]              rem_sh;
    logic [TOT_W:0]              rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[lsch_pkg::RND_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = lsch_pkg::RCNT_W'(lsch_pkg::RND_W);
            busy_next = 1'b1;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[lsch_pkg::RND_W-2:0], 1'b0};
            // remainder stays below the divisor, so the low bits hold it
            rem_next = (rem_sh >= {1'b0, divisor}) ? rem_sub[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lsch_pkg::RCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/lottery_scheduler_core.sv -----
// Top level of the lottery scheduler: sequencer, process table and remainder unit.
//
// Lottery scheduler core. Holds NUM_ENTRIES process entries (run state and
// ticket count) and the index of the running entry. A set request
// (tuser = 0) writes one entry and returns an all-zero result; indexes past
// the table are dropped. A reschedule request (tuser = 1) demotes the
// running entry to ready if it is still running, sums the tickets of all
// ready entries, draws random_raw mod total (0 raised to 1), and promotes
// the first ready entry whose running ticket sum reaches the draw. With no
// ready tickets nothing is promoted and found is 0. Entries in state 3 or
// in state running other than the tracked one sit out the draw.
// A reschedule's result takes two walks over the table through its single
// read port, one entry per cycle behind the registered read, and the
// 32 steps of the bit-serial remainder unit for the draw; the second walk
// stops early when the winner sits early in the table. With no ready
// tickets the draw and second walk are skipped. s_tready is high only
// while the sequencer is idle, which it reaches in the same cycle that the
// result is loaded; a finished result waits in the output register and the
// next request can be taken meanwhile. The table resets at once (per-entry
// valid bits), no clearing pass.
module lottery_scheduler_core #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[3:0], entry_state[5:4], entry_tickets[21:6],
    // random_raw[53:22], zero fill [55:54]
    input  logic [lsch_pkg::S_DATA_W-1:0] s_tdata,
    // action[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // winner_index[3:0], ticket_total[23:4]
    output logic [lsch_pkg::M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic [0:0]                    m_tuser
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
    localparam int TOT_W  = lsch_pkg::TICKET_W + IDX_W;
    localparam int WIDE_W = (TOT_W > lsch_pkg::OUT_TOT_W) ? TOT_W : lsch_pkg::OUT_TOT_W;
    localparam int WIDX_W = (IDX_W > lsch_pkg::IDX_PORT_W) ? IDX_W : lsch_pkg::IDX_PORT_W;

    // request fields
    logic                             in_act;
    logic [lsch_pkg::IDX_PORT_W-1:0]  in_idx;
    logic [1:0]                       in_state;
    logic [lsch_pkg::TICKET_W-1:0]    in_tk;
    logic [lsch_pkg::RND_W-1:0]       in_rnd;
    logic                             in_ok;

    assign in_act   = s_tuser[0];
    assign in_idx   = s_tdata[3:0];
    assign in_state = s_tdata[5:4];
    assign in_tk    = s_tdata[21:6];
    assign in_rnd   = s_tdata[53:22];
    assign in_ok    = (int'(in_idx) < NUM_ENTRIES);

    lsch_pkg::lsch_fsm_t state_reg, state_next;

    logic [lsch_pkg::RND_W-1:0]      rnd_reg, rnd_next;
    logic [IDX_W-1:0]                run_idx_reg, run_idx_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            vld_reg, vld_next;
    logic [IDX_W-1:0]                data_idx_reg, data_idx_next;
    logic [TOT_W-1:0]                total_reg, total_next;
    logic [TOT_W-1:0]                sum_reg, sum_next;
    logic [TOT_W-1:0]                draw_reg, draw_next;
    logic [IDX_W-1:0]                win_idx_reg, win_idx_next;
    logic [lsch_pkg::TICKET_W-1:0]   win_tk_reg, win_tk_next;
    logic                            found_reg, found_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            o_found_reg, o_found_next;
    logic [lsch_pkg::IDX_PORT_W-1:0] o_win_reg, o_win_next;
    logic [lsch_pkg::OUT_TOT_W-1:0]  o_total_reg, o_total_next;

    // table and remainder unit hookup
    lsch_pkg::lsch_wr_t              tbl_wr;
    logic [IDX_W-1:0]                tbl_wr_addr;
    logic [IDX_W-1:0]                tbl_rd_addr;
    logic [1:0]                      rd_state;
    logic [lsch_pkg::TICKET_W-1:0]   rd_tickets;
    logic                            mod_start;
    logic                            mod_done;
    logic [TOT_W-1:0]                mod_rem;

    logic                            accept;
    logic                            out_free;
    logic                            issue;
    logic                            rd_ready;
    logic [TOT_W-1:0]                sum_plus;
    logic                            hit;
    logic                            walk_done;
    logic [WIDX_W-1:0]               win_wide;
    logic [WIDE_W-1:0]               total_wide;

    lsch_table #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr),
        .wr_addr    (tbl_wr_addr),
        .rd_addr    (tbl_rd_addr),
        .rd_state   (rd_state),
        .rd_tickets (rd_tickets)
    );

    lsch_mod #(
        .TOT_W (TOT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rnd_reg),
        .divisor  (total_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    // walks issue one read per cycle; data shows up in the next cycle
    assign issue     = (int'(cnt_reg) < NUM_ENTRIES);
    assign rd_ready  = vld_reg && (rd_state == lsch_pkg::ST_READY);
    assign sum_plus  = sum_reg + TOT_W'(rd_tickets);
    assign hit       = (state_reg == lsch_pkg::S_SCAN) && rd_ready && (sum_plus >= draw_reg);
    assign walk_done = !issue && !vld_reg;
    assign win_wide  = WIDX_W'(win_idx_reg);
    assign total_wide = WIDE_W'(total_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsch_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_act == lsch_pkg::ACT_RESCHED) ? lsch_pkg::S_RD_RUN
                                                                   : lsch_pkg::S_FIN;
                end
            end
            lsch_pkg::S_RD_RUN:  state_next = lsch_pkg::S_CHK_RUN;
            lsch_pkg::S_CHK_RUN: state_next = lsch_pkg::S_SUM;
            lsch_pkg::S_SUM:
            begin
                if (walk_done)
                begin
                    state_next = (total_reg == '0) ? lsch_pkg::S_FIN : lsch_pkg::S_DIV;
                end
            end
            lsch_pkg::S_DIV:     state_next = lsch_pkg::S_DIV_WAIT;
            lsch_pkg::S_DIV_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = lsch_pkg::S_SCAN;
                end
            end
            lsch_pkg::S_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = lsch_pkg::S_WIN;
                end
                else if (walk_done)
                begin
                    state_next = lsch_pkg::S_FIN;
                end
            end
            lsch_pkg::S_WIN:     state_next = lsch_pkg::S_FIN;
            lsch_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = lsch_pkg::S_IDLE;
                end
            end
            default:             state_next = lsch_pkg::S_IDLE;
        endcase
    end

    // control outputs: handshake, table ports, remainder start
    always_comb
    begin
        s_tready       = 1'b0;
        tbl_wr.en      = 1'b0;
        tbl_wr.state   = rd_state;
        tbl_wr.tickets = rd_tickets;
        tbl_wr_addr    = run_idx_reg;
        tbl_rd_addr    = cnt_reg[IDX_W-1:0];
        mod_start      = 1'b0;
        unique case (state_reg)
            lsch_pkg::S_IDLE:
            begin
                s_tready       = 1'b1;
                tbl_wr.en      = s_tvalid && (in_act == lsch_pkg::ACT_SET) && in_ok;
                tbl_wr.state   = in_state;
                tbl_wr.tickets = in_tk;
                tbl_wr_addr    = IDX_W'(in_idx);
            end
            lsch_pkg::S_RD_RUN:
            begin
                tbl_rd_addr = run_idx_reg;
            end
            lsch_pkg::S_CHK_RUN:
            begin
                // demote the tracked entry, keep its tickets
                tbl_wr.en    = (rd_state == lsch_pkg::ST_RUNNING);
                tbl_wr.state = lsch_pkg::ST_READY;
            end
            lsch_pkg::S_DIV:
            begin
                mod_start = 1'b1;
            end
            lsch_pkg::S_WIN:
            begin
                tbl_wr.en      = 1'b1;
                tbl_wr.state   = lsch_pkg::ST_RUNNING;
                tbl_wr.tickets = win_tk_reg;
                tbl_wr_addr    = win_idx_reg;
            end
            lsch_pkg::S_SUM, lsch_pkg::S_DIV_WAIT, lsch_pkg::S_SCAN, lsch_pkg::S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        rnd_next      = rnd_reg;
        run_idx_next  = run_idx_reg;
        cnt_next      = cnt_reg;
        vld_next      = vld_reg;
        data_idx_next = data_idx_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        draw_next     = draw_reg;
        win_idx_next  = win_idx_reg;
        win_tk_next   = win_tk_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_found_next  = o_found_reg;
        o_win_next    = o_win_reg;
        o_total_next  = o_total_reg;

        unique case (state_reg)
            lsch_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rnd_next     = in_rnd;
                    found_next   = 1'b0;
                    win_idx_next = '0;
                    total_next   = '0;
                end
            end
            lsch_pkg::S_CHK_RUN:
            begin
                cnt_next   = '0;
                vld_next   = 1'b0;
                total_next = '0;
            end
            lsch_pkg::S_SUM:
            begin
                vld_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_ready)
                begin
                    total_next = total_reg + TOT_W'(rd_tickets);
                end
            end
            lsch_pkg::S_DIV:
            begin
                cnt_next = '0;
                vld_next = 1'b0;
                sum_next = '0;
            end
            lsch_pkg::S_DIV_WAIT:
            begin
                if (mod_done)
                begin
                    draw_next = (mod_rem == '0) ? TOT_W'(1) : mod_rem;
                end
            end
            lsch_pkg::S_SCAN:
            begin
                vld_next      = issue;
                data_idx_next = cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_ready)
                begin
                    sum_next = sum_plus;
                end
                if (hit)
                begin
                    found_next   = 1'b1;
                    win_idx_next = data_idx_reg;
                    win_tk_next  = rd_tickets;
                end
            end
            lsch_pkg::S_WIN:
            begin
                run_idx_next = win_idx_reg;
            end
            lsch_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_found_next = found_reg;
                    o_win_next   = win_wide[lsch_pkg::IDX_PORT_W-1:0];
                    o_total_next = total_wide[lsch_pkg::OUT_TOT_W-1:0];
                end
            end
            lsch_pkg::S_RD_RUN:
            begin
            end
            default:
            begin
            end
        endcase

        // during the sum walk too, the read data index tracks the address issued last cycle
        if (state_reg == lsch_pkg::S_SUM)
        begin
            data_idx_next = cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lsch_pkg::S_IDLE;
            run_idx_reg <= '0;
            cnt_reg     <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            run_idx_reg <= run_idx_next;
            cnt_reg     <= cnt_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg      <= rnd_next;
        data_idx_reg <= data_idx_next;
        total_reg    <= total_next;
        sum_reg      <= sum_next;
        draw_reg     <= draw_next;
        win_idx_reg  <= win_idx_next;
        win_tk_reg   <= win_tk_next;
        found_reg    <= found_next;
        o_found_reg  <= o_found_next;
        o_win_reg    <= o_win_next;
        o_total_reg  <= o_total_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_total_reg, o_win_reg};
    assign m_tuser  = o_found_reg;

endmodule

// ----- sv/lsch_checker.sv -----
// Port-level checker for the lottery scheduler, bound to the top level.
`include "lottery_scheduler_core_defines.svh"

module lsch_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lsch_pkg::M_DATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    // a stalled result holds
    `LSCH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one request at a time: busy right after taking a reschedule
    `LSCH_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready && (s_tuser[0] == lsch_pkg::ACT_RESCHED), !s_tready)

    // no winner means winner index reads zero
    `LSCH_ASSERT_SAME(a_nowin_zero, m_tvalid && !m_tuser[0], m_tdata[lsch_pkg::IDX_PORT_W-1:0] == '0)

    // a winner needs tickets in play
    `LSCH_ASSERT_SAME(a_win_tickets, m_tvalid && m_tuser[0], m_tdata[lsch_pkg::M_DATA_W-1:lsch_pkg::IDX_PORT_W] != '0)

endmodule

bind lottery_scheduler_core lsch_checker u_lsch_checker (.*);
